/* rtl/json_token_lexer_macros.svh */
// Assertion macros for the JSON token lexer checker.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef JSON_TOKEN_LEXER_MACROS_SVH
`define JSON_TOKEN_LEXER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define JTL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("json_token_lexer: assertion failed");

// next-cycle implication, disabled while in reset
`define JTL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("json_token_lexer: assertion failed");

`endif

/* rtl/jtl_pkg.sv */
// Shared types, codes and lookup functions for the JSON token lexer.
// No dependencies; used by every module of the block.
`default_nettype none

package jtl_pkg;

    localparam int NRES = 3;

    // input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // token kinds
    localparam logic [3:0] KIND_LBRACE = 4'd0;
    localparam logic [3:0] KIND_RBRACE = 4'd1;
    localparam logic [3:0] KIND_LBRACK = 4'd2;
    localparam logic [3:0] KIND_RBRACK = 4'd3;
    localparam logic [3:0] KIND_COLON  = 4'd4;
    localparam logic [3:0] KIND_COMMA  = 4'd5;
    localparam logic [3:0] KIND_STRING = 4'd6;
    localparam logic [3:0] KIND_NUMBER = 4'd7;
    localparam logic [3:0] KIND_BOOL   = 4'd8;
    localparam logic [3:0] KIND_NULL   = 4'd9;
    localparam logic [3:0] KIND_ERROR  = 4'd10;

    // error codes
    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_END        = 4'd1;
    localparam logic [3:0] ERR_ESCAPE     = 4'd2;
    localparam logic [3:0] ERR_DOT        = 4'd3;
    localparam logic [3:0] ERR_EXPONENT   = 4'd4;
    localparam logic [3:0] ERR_EXP_EMPTY  = 4'd5;
    localparam logic [3:0] ERR_LONE_MINUS = 4'd6;
    localparam logic [3:0] ERR_LEAD_ZERO  = 4'd7;
    localparam logic [3:0] ERR_UNEXPECTED = 4'd8;

    // keyword selectors
    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_E_UP   = 8'h45;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_B_LO   = 8'h62;
    localparam logic [7:0] CH_E_LO   = 8'h65;
    localparam logic [7:0] CH_F_LO   = 8'h66;
    localparam logic [7:0] CH_L_LO   = 8'h6C;
    localparam logic [7:0] CH_N_LO   = 8'h6E;
    localparam logic [7:0] CH_R_LO   = 8'h72;
    localparam logic [7:0] CH_S_LO   = 8'h73;
    localparam logic [7:0] CH_T_LO   = 8'h74;
    localparam logic [7:0] CH_U_LO   = 8'h75;
    localparam logic [7:0] CH_V_LO   = 8'h76;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_STR  = 5'b00010,
        MODE_ESC  = 5'b00100,
        MODE_KEY  = 5'b01000,
        MODE_NUM  = 5'b10000
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic       halted;
        logic [1:0] kw_which;
        logic [2:0] kw_pos;
        logic       seen_dec;
        logic       seen_exp;
        logic [7:0] prev_char;
        logic [1:0] num_len;
        logic [7:0] first_char;
        logic       lz_bad;
        logic       held_dot;
    } lex_state_t;

    typedef struct packed {
        logic [3:0] kind;
        logic       has_char;
        logic [7:0] ch;
        logic       last;
        logic [3:0] err;
    } result_t;

    function automatic result_t mk_res(logic [3:0] kind, logic has_char, logic [7:0] ch,
                                       logic last, logic [3:0] err);
        result_t r;
        r.kind     = kind;
        r.has_char = has_char;
        r.ch       = ch;
        r.last     = last;
        r.err      = err;
        return r;
    endfunction

    function automatic lex_state_t clear_number(lex_state_t s);
        lex_state_t t;
        t            = s;
        t.seen_dec   = 1'b0;
        t.seen_exp   = 1'b0;
        t.prev_char  = 8'h00;
        t.num_len    = 2'd0;
        t.first_char = 8'h00;
        t.lz_bad     = 1'b0;
        t.held_dot   = 1'b0;
        return t;
    endfunction

    function automatic lex_state_t fail_state(lex_state_t s);
        lex_state_t t;
        t        = clear_number(s);
        t.halted = 1'b1;
        t.mode   = MODE_IDLE;
        t.kw_pos = 3'd0;
        return t;
    endfunction

    function automatic lex_state_t reset_state();
        lex_state_t t;
        t      = '0;
        t.mode = MODE_IDLE;
        return t;
    endfunction

    function automatic logic is_exp(logic [7:0] c);
        return (c == CH_E_LO) || (c == CH_E_UP);
    endfunction

    // {valid, translated character}
    function automatic logic [8:0] esc_map(logic [7:0] c);
        logic [8:0] r;
        unique case (c)
            CH_QUOTE:  r = {1'b1, CH_QUOTE};
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            CH_N_LO:   r = {1'b1, CH_LF};
            CH_T_LO:   r = {1'b1, CH_TAB};
            CH_R_LO:   r = {1'b1, CH_CR};
            CH_B_LO:   r = {1'b1, CH_BS};
            CH_F_LO:   r = {1'b1, CH_FF};
            CH_V_LO:   r = {1'b1, CH_VT};
            CH_A_LO:   r = {1'b1, CH_BEL};
            CH_0:      r = {1'b1, CH_NUL};
            default:   r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] kw_len(logic [1:0] w);
        return (w == KW_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [7:0] kw_char(logic [1:0] w, logic [2:0] p);
        logic [7:0] r;
        unique case ({w, p})
            {KW_TRUE, 3'd0}:  r = CH_T_LO;
            {KW_TRUE, 3'd1}:  r = CH_R_LO;
            {KW_TRUE, 3'd2}:  r = CH_U_LO;
            {KW_TRUE, 3'd3}:  r = CH_E_LO;
            {KW_FALSE, 3'd0}: r = CH_F_LO;
            {KW_FALSE, 3'd1}: r = CH_A_LO;
            {KW_FALSE, 3'd2}: r = CH_L_LO;
            {KW_FALSE, 3'd3}: r = CH_S_LO;
            {KW_FALSE, 3'd4}: r = CH_E_LO;
            {KW_NULL, 3'd0}:  r = CH_N_LO;
            {KW_NULL, 3'd1}:  r = CH_U_LO;
            {KW_NULL, 3'd2}:  r = CH_L_LO;
            {KW_NULL, 3'd3}:  r = CH_L_LO;
            default:          r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/json_token_lexer.sv */
// JSON token lexer top level: input register, lexer state, step logic and
// result buffer. Depends on jtl_pkg, jtl_step and jtl_out_buf.
//
// Takes one JSON text byte (or an end-of-text marker) per input transaction
// and gives token results on the output stream, one result per transaction,
// tlast on the final result of each token or on an error. An input byte is
// registered and then lexed into a three-entry result buffer once the buffer
// is free; its first result is offered from the buffer's registers. A byte
// gives at most three results and the buffer hands out one a cycle while
// m_axis_tready is high: bytes that give zero or one result then flow at one
// per cycle, and a byte that gives more results stalls the input until the
// buffer is down to its final result, plus every cycle in which
// m_axis_tready is low. s_axis_tready follows m_axis_tready combinationally
// while the buffer holds its final result.
// After an error no results appear until the end-of-text marker.
`default_nettype none

module json_token_lexer (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire         s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] char_out, [11:8] error_code, [15:12] zero
    output logic [4:0]  m_axis_tuser,   // [3:0] token_kind, [4] has_char
    output logic        m_axis_tlast
);

    logic                in_valid_reg, in_valid_next;
    logic                in_op_reg;
    logic [7:0]          in_byte_reg;
    jtl_pkg::lex_state_t lex_state_reg, lex_state_next;
    jtl_pkg::result_t    step_res [jtl_pkg::NRES];
    logic [1:0]          step_cnt;
    jtl_pkg::result_t    out_res;
    logic                buf_free;
    logic                proc;
    logic                s_hs;

    assign proc          = in_valid_reg && buf_free;
    assign s_axis_tready = !in_valid_reg || proc;
    assign s_hs          = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_hs) in_valid_next = 1'b1;
        else if (proc) in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            lex_state_reg <= jtl_pkg::reset_state();
        end else begin
            in_valid_reg <= in_valid_next;
            if (proc) lex_state_reg <= lex_state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_hs) begin
            in_op_reg   <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    jtl_step u_step (
        .cur   (lex_state_reg),
        .op    (in_op_reg),
        .c     (in_byte_reg),
        .nxt   (lex_state_next),
        .res   (step_res),
        .n_res (step_cnt)
    );

    jtl_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (proc),
        .load_cnt  (step_cnt),
        .load_res  (step_res),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_res   (out_res),
        .free      (buf_free)
    );

    assign m_axis_tdata = {4'b0000, out_res.err, out_res.ch};
    assign m_axis_tuser = {out_res.has_char, out_res.kind};
    assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

/* rtl/jtl_step.sv */
// Lexer step logic: next lexer state and up to three results for one item.
// Depends on jtl_pkg.
`default_nettype none

module jtl_step (
    input  wire jtl_pkg::lex_state_t cur,
    input  wire                      op,
    input  wire  [7:0]               c,
    output jtl_pkg::lex_state_t      nxt,
    output jtl_pkg::result_t         res [jtl_pkg::NRES],
    output logic [1:0]               n_res
);

    always_comb begin
        jtl_pkg::lex_state_t s;
        logic [1:0] n;
        logic       do_close;
        logic       do_idle;
        logic       do_ext;
        logic       is_end;
        logic       dig;
        logic       c_exp;
        logic       sign_ok;
        logic [8:0] esc;
        logic [1:0] w;
        logic [2:0] len;
        logic [2:0] p;

        s        = cur;
        n        = 2'd0;
        do_close = 1'b0;
        do_idle  = 1'b0;
        do_ext   = 1'b0;
        is_end   = (op == jtl_pkg::OP_END);
        dig      = (c >= jtl_pkg::CH_0) && (c <= jtl_pkg::CH_9);
        c_exp    = jtl_pkg::is_exp(c);
        esc      = jtl_pkg::esc_map(c);
        w        = (cur.kw_which == 2'd3) ? jtl_pkg::KW_TRUE : cur.kw_which;
        len      = jtl_pkg::kw_len(w);
        p        = (cur.kw_pos < len) ? cur.kw_pos : 3'd0;
        sign_ok  = ((c == jtl_pkg::CH_MINUS) || (c == jtl_pkg::CH_PLUS)) &&
                   ((cur.num_len == 2'd0) || jtl_pkg::is_exp(cur.prev_char));
        for (int i = 0; i < jtl_pkg::NRES; i++) res[i] = '0;

        if (is_end) begin
            if (!cur.halted) begin
                unique case (cur.mode)
                    jtl_pkg::MODE_STR, jtl_pkg::MODE_ESC:
                    begin
                        res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_ERROR, 1'b0, 8'h00, 1'b1,
                                                 jtl_pkg::ERR_END);
                        n = n + 2'd1;
                    end
                    jtl_pkg::MODE_KEY:
                    begin
                        res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_ERROR, 1'b0, 8'h00, 1'b1,
                                                 jtl_pkg::ERR_UNEXPECTED);
                        n = n + 2'd1;
                    end
                    jtl_pkg::MODE_NUM: do_close = 1'b1;
                    default: ;
                endcase
            end
        end else if (!cur.halted) begin
            unique case (cur.mode)
                jtl_pkg::MODE_STR:
                begin
                    if (c == jtl_pkg::CH_QUOTE) begin
                        res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_STRING, 1'b0, 8'h00, 1'b1,
                                                 jtl_pkg::ERR_NONE);
                        n = n + 2'd1;
                        s.mode = jtl_pkg::MODE_IDLE;
                    end else if (c == jtl_pkg::CH_BSLASH) begin
                        s.mode = jtl_pkg::MODE_ESC;
                    end else begin
                        res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_STRING, 1'b1, c, 1'b0,
                                                 jtl_pkg::ERR_NONE);
                        n = n + 2'd1;
                    end
                end
                jtl_pkg::MODE_ESC:
                begin
                    if (!esc[8]) begin
                        res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_ERROR, 1'b0, 8'h00, 1'b1,
                                                 jtl_pkg::ERR_ESCAPE);
                        n = n + 2'd1;
                        s = jtl_pkg::fail_state(s);
                    end else begin
                        res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_STRING, 1'b1, esc[7:0], 1'b0,
                                                 jtl_pkg::ERR_NONE);
                        n = n + 2'd1;
                        s.mode = jtl_pkg::MODE_STR;
                    end
                end
                jtl_pkg::MODE_KEY:
                begin
                    if ((p == 3'd0) || (c != jtl_pkg::kw_char(w, p))) begin
                        res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_ERROR, 1'b0, 8'h00, 1'b1,
                                                 jtl_pkg::ERR_UNEXPECTED);
                        n = n + 2'd1;
                        s = jtl_pkg::fail_state(s);
                    end else if ((p + 3'd1) == len) begin
                        res[n] = jtl_pkg::mk_res(
                            (w == jtl_pkg::KW_NULL) ? jtl_pkg::KIND_NULL : jtl_pkg::KIND_BOOL,
                            1'b1, jtl_pkg::kw_char(w, 3'd0), 1'b1, jtl_pkg::ERR_NONE);
                        n = n + 2'd1;
                        s.mode   = jtl_pkg::MODE_IDLE;
                        s.kw_pos = 3'd0;
                    end else begin
                        s.kw_pos = p + 3'd1;
                    end
                end
                jtl_pkg::MODE_NUM:
                begin
                    if (dig || (c == jtl_pkg::CH_DOT) || c_exp || sign_ok) do_ext = 1'b1;
                    else do_close = 1'b1;
                end
                default: do_idle = 1'b1;
            endcase
        end

        // number close, at end of text or on a byte that cannot continue it
        if (do_close) begin
            if (jtl_pkg::is_exp(s.prev_char)) begin
                res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_ERROR, 1'b0, 8'h00, 1'b1,
                                         jtl_pkg::ERR_EXP_EMPTY);
                n = n + 2'd1;
                s = jtl_pkg::fail_state(s);
            end else if (s.prev_char == jtl_pkg::CH_MINUS) begin
                res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_ERROR, 1'b0, 8'h00, 1'b1,
                                         jtl_pkg::ERR_LONE_MINUS);
                n = n + 2'd1;
                s = jtl_pkg::fail_state(s);
            end else if (s.lz_bad) begin
                res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_ERROR, 1'b0, 8'h00, 1'b1,
                                         jtl_pkg::ERR_LEAD_ZERO);
                n = n + 2'd1;
                s = jtl_pkg::fail_state(s);
            end else begin
                if (s.held_dot) begin
                    res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_NUMBER, 1'b1, jtl_pkg::CH_DOT,
                                             1'b0, jtl_pkg::ERR_NONE);
                    n = n + 2'd1;
                end
                res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_NUMBER, 1'b0, 8'h00, 1'b1,
                                         jtl_pkg::ERR_NONE);
                n = n + 2'd1;
                s.mode = jtl_pkg::MODE_IDLE;
                s = jtl_pkg::clear_number(s);
                do_idle = !is_end;
            end
        end

        // byte between tokens
        if (do_idle) begin
            s.mode = jtl_pkg::MODE_IDLE;
            case (c) inside
                jtl_pkg::CH_SPACE, jtl_pkg::CH_TAB, jtl_pkg::CH_LF,
                jtl_pkg::CH_VT, jtl_pkg::CH_FF, jtl_pkg::CH_CR: ;
                jtl_pkg::CH_LBRACE:
                begin
                    res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_LBRACE, 1'b1, c, 1'b1,
                                             jtl_pkg::ERR_NONE);
                    n = n + 2'd1;
                end
                jtl_pkg::CH_RBRACE:
                begin
                    res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_RBRACE, 1'b1, c, 1'b1,
                                             jtl_pkg::ERR_NONE);
                    n = n + 2'd1;
                end
                jtl_pkg::CH_LBRACK:
                begin
                    res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_LBRACK, 1'b1, c, 1'b1,
                                             jtl_pkg::ERR_NONE);
                    n = n + 2'd1;
                end
                jtl_pkg::CH_RBRACK:
                begin
                    res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_RBRACK, 1'b1, c, 1'b1,
                                             jtl_pkg::ERR_NONE);
                    n = n + 2'd1;
                end
                jtl_pkg::CH_COLON:
                begin
                    res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_COLON, 1'b1, c, 1'b1,
                                             jtl_pkg::ERR_NONE);
                    n = n + 2'd1;
                end
                jtl_pkg::CH_COMMA:
                begin
                    res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_COMMA, 1'b1, c, 1'b1,
                                             jtl_pkg::ERR_NONE);
                    n = n + 2'd1;
                end
                jtl_pkg::CH_QUOTE: s.mode = jtl_pkg::MODE_STR;
                jtl_pkg::CH_T_LO:
                begin
                    s.kw_which = jtl_pkg::KW_TRUE;
                    s.kw_pos   = 3'd1;
                    s.mode     = jtl_pkg::MODE_KEY;
                end
                jtl_pkg::CH_F_LO:
                begin
                    s.kw_which = jtl_pkg::KW_FALSE;
                    s.kw_pos   = 3'd1;
                    s.mode     = jtl_pkg::MODE_KEY;
                end
                jtl_pkg::CH_N_LO:
                begin
                    s.kw_which = jtl_pkg::KW_NULL;
                    s.kw_pos   = 3'd1;
                    s.mode     = jtl_pkg::MODE_KEY;
                end
                [jtl_pkg::CH_0 : jtl_pkg::CH_9], jtl_pkg::CH_MINUS, jtl_pkg::CH_DOT:
                begin
                    s = jtl_pkg::clear_number(s);
                    s.mode = jtl_pkg::MODE_NUM;
                    do_ext = 1'b1;
                end
                default:
                begin
                    res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_ERROR, 1'b0, 8'h00, 1'b1,
                                             jtl_pkg::ERR_UNEXPECTED);
                    n = n + 2'd1;
                    s = jtl_pkg::fail_state(s);
                end
            endcase
        end

        // number continues with this byte
        if (do_ext) begin
            if ((c == jtl_pkg::CH_DOT) && (s.seen_dec || s.seen_exp)) begin
                res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_ERROR, 1'b0, 8'h00, 1'b1,
                                         jtl_pkg::ERR_DOT);
                n = n + 2'd1;
                s = jtl_pkg::fail_state(s);
            end else if (c_exp && s.seen_exp) begin
                res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_ERROR, 1'b0, 8'h00, 1'b1,
                                         jtl_pkg::ERR_EXPONENT);
                n = n + 2'd1;
                s = jtl_pkg::fail_state(s);
            end else begin
                if (s.held_dot) begin
                    if (dig) begin
                        res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_NUMBER, 1'b1, jtl_pkg::CH_0,
                                                 1'b0, jtl_pkg::ERR_NONE);
                        n = n + 2'd1;
                    end
                    res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_NUMBER, 1'b1, jtl_pkg::CH_DOT,
                                             1'b0, jtl_pkg::ERR_NONE);
                    n = n + 2'd1;
                    s.held_dot = 1'b0;
                end
                if (c == jtl_pkg::CH_DOT) s.seen_dec = 1'b1;
                if (c_exp) s.seen_exp = 1'b1;
                if ((s.num_len == 2'd1) && (s.first_char == jtl_pkg::CH_0) &&
                    (c != jtl_pkg::CH_DOT))
                    s.lz_bad = 1'b1;
                // a dot that opens the number waits to see whether a zero goes in front
                if ((c == jtl_pkg::CH_DOT) && ((s.num_len == 2'd0) ||
                    ((s.num_len == 2'd1) && (s.first_char == jtl_pkg::CH_MINUS)))) begin
                    s.held_dot = 1'b1;
                end else begin
                    res[n] = jtl_pkg::mk_res(jtl_pkg::KIND_NUMBER, 1'b1, c, 1'b0,
                                             jtl_pkg::ERR_NONE);
                    n = n + 2'd1;
                end
                if (s.num_len == 2'd0) s.first_char = c;
                if (s.num_len != 2'd3) s.num_len = s.num_len + 2'd1;
                s.prev_char = c;
            end
        end

        if (is_end) s = jtl_pkg::reset_state();

        nxt   = s;
        n_res = n;
    end

endmodule

`default_nettype wire

/* rtl/jtl_out_buf.sv */
// Result buffer: holds the results of one item and hands them out one per
// transaction on the master side. Depends on jtl_pkg.
`default_nettype none

module jtl_out_buf (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     load,
    input  wire  [1:0]              load_cnt,
    input  wire jtl_pkg::result_t   load_res [jtl_pkg::NRES],
    input  wire                     out_ready,
    output logic                    out_valid,
    output jtl_pkg::result_t        out_res,
    output logic                    free
);

    jtl_pkg::result_t rbuf_reg [jtl_pkg::NRES];
    logic [1:0]       rem_reg, rem_next;
    logic [1:0]       rd_reg, rd_next;

    assign out_valid = (rem_reg != 2'd0);
    assign out_res   = rbuf_reg[rd_reg];
    // room for a fresh item when empty, or once the last waiting result goes this cycle
    assign free      = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && out_ready);

    always_comb begin
        rem_next = rem_reg;
        rd_next  = rd_reg;
        if (load) begin
            rem_next = load_cnt;
            rd_next  = 2'd0;
        end else if (out_valid && out_ready) begin
            rem_next = rem_reg - 2'd1;
            rd_next  = rd_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rem_reg <= 2'd0;
            rd_reg  <= 2'd0;
        end else begin
            rem_reg <= rem_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            for (int i = 0; i < jtl_pkg::NRES; i++) rbuf_reg[i] <= load_res[i];
        end
    end

endmodule

`default_nettype wire

/* rtl/jtl_checker.sv */
// Port-level checks for the JSON token lexer, bound to the top level.
// Depends on jtl_pkg and json_token_lexer_macros.svh.
`default_nettype none
`include "json_token_lexer_macros.svh"

module jtl_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire [7:0]  s_axis_tdata,
    input wire        s_axis_tuser,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata,
    input wire [4:0]  m_axis_tuser,
    input wire        m_axis_tlast
);

    logic is_err;
    logic in_hs;
    assign is_err = (m_axis_tuser[3:0] == jtl_pkg::KIND_ERROR);
    assign in_hs  = s_axis_tvalid && s_axis_tready;

    // a stalled input transaction holds
    `JTL_ASSERT_NEXT(a_in_hold, s_axis_tvalid && !s_axis_tready,
        s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))

    // a stalled result transaction holds
    `JTL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // errors close their run and carry no character
    `JTL_ASSERT_NOW(a_err_shape, m_axis_tvalid && is_err,
        m_axis_tlast && !m_axis_tuser[4] && (m_axis_tdata[7:0] == 8'h00) &&
        (m_axis_tdata[11:8] != jtl_pkg::ERR_NONE))

    // an error code only ever comes with the error kind
    `JTL_ASSERT_NOW(a_code_kind, m_axis_tvalid && (m_axis_tdata[11:8] != jtl_pkg::ERR_NONE),
        is_err)

    // with the output empty and no input transaction over the whole antecedent, it stays empty
    `JTL_ASSERT_NEXT(a_no_early_out,
        (!m_axis_tvalid && !in_hs) ##1 (!m_axis_tvalid && !in_hs),
        !m_axis_tvalid)

endmodule

bind json_token_lexer jtl_checker u_jtl_checker (.*);

`default_nettype wire
